### design/ale_pkg.sv
// Shared definitions for the array list engine: list depth, derived widths,
// opcode and status codes, and the types passed between the engine modules.
// No dependencies.
package ale_pkg;

  localparam int DEPTH = 16;
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    OP_INSERT_AT     = 3'd0,
    OP_REMOVE_VALUE  = 3'd1,
    OP_SORTED_INSERT = 3'd2,
    OP_REVERSE       = 3'd3,
    OP_READ          = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef logic [DEPTH-1:0][7:0] entry_array_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] read_value;
  } result_t;

endpackage

### design/ale_update.sv
// Next-state and result logic of the array list engine for one request.
// Computes the updated entries and length from the registered request.
// Depends on ale_pkg.
module ale_update
  import ale_pkg::*;
(
  input  logic [2:0]       opcode,
  input  logic [4:0]       position,
  input  logic [7:0]       element,
  input  entry_array_t     entries,
  input  logic [LEN_W-1:0] length,
  output entry_array_t     entries_next,
  output logic [LEN_W-1:0] length_next,
  output result_t          res
);

  logic [31:0]                 len32;
  logic [31:0]                 pos32;
  logic [31:0]                 sort_pos;
  logic [31:0]                 ins_pos;
  logic [LEN_W-1:0]            rem_len;
  logic [DEPTH-1:0]            keep;
  logic [DEPTH-1:0][LEN_W-1:0] keep_before;
  logic                        full;
  entry_array_t                ins_entries;
  entry_array_t                rem_entries;
  entry_array_t                rev_entries;

  assign len32 = 32'(length);
  assign pos32 = 32'(position);
  assign full  = (len32 == DEPTH);

  // The sorted position is the first stored entry larger than the element.
  always_comb begin
    sort_pos = len32;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((32'(i) < len32) && (element < entries[i])) begin
        sort_pos = 32'(i);
      end
    end
  end

  assign ins_pos = (op_t'(opcode) == OP_SORTED_INSERT) ? sort_pos : pos32;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(i) < ins_pos) begin
        ins_entries[i] = entries[i];
      end else if (32'(i) == ins_pos) begin
        ins_entries[i] = element;
      end else if (i > 0) begin
        ins_entries[i] = entries[(i > 0) ? i - 1 : 0];
      end else begin
        ins_entries[i] = entries[i];
      end
    end
  end

  // Kept entries move down to the slot given by the number of kept entries
  // before them.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      keep[k] = (32'(k) < len32) && (entries[k] != element);
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      keep_before[k] = LEN_W'($countones(keep & ({DEPTH{1'b1}} >> (DEPTH - k))));
    end
  end

  assign rem_len = LEN_W'($countones(keep));

  always_comb begin
    rem_entries = entries;
    for (int j = 0; j < DEPTH; j++) begin
      for (int k = j; k < DEPTH; k++) begin
        if (keep[k] && (keep_before[k] == LEN_W'(j))) begin
          rem_entries[j] = entries[k];
        end
      end
    end
  end

  always_comb begin
    logic [31:0] ridx;
    for (int i = 0; i < DEPTH; i++) begin
      ridx = len32 - 32'd1 - 32'(i);
      if (32'(i) < len32) begin
        rev_entries[i] = entries[ridx[IDX_W-1:0]];
      end else begin
        rev_entries[i] = entries[i];
      end
    end
  end

  always_comb begin
    entries_next   = entries;
    length_next    = length;
    res.status     = ST_OK;
    res.read_value = '0;
    case (op_t'(opcode))
      OP_INSERT_AT: begin
        if (full) begin
          res.status = ST_FULL;
        end else if (pos32 > len32) begin
          res.status = ST_BAD_POS;
        end else begin
          entries_next = ins_entries;
          length_next  = length + LEN_W'(1);
        end
      end
      OP_SORTED_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          entries_next = ins_entries;
          length_next  = length + LEN_W'(1);
        end
      end
      OP_REMOVE_VALUE: begin
        entries_next = rem_entries;
        length_next  = rem_len;
        if (rem_len == length) begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_REVERSE: begin
        entries_next = rev_entries;
      end
      OP_READ: begin
        if (pos32 < len32) begin
          res.read_value = entries[pos32[IDX_W-1:0]];
        end else begin
          res.status = ST_BAD_POS;
        end
      end
      default: begin
        entries_next = entries;
      end
    endcase
  end

endmodule

### design/array_list_engine_core.sv
// Array list engine: a bounded list of byte entries with insert, remove,
// sorted insert, reverse and read operations.
// Depends on ale_pkg and ale_update.
//
// A request is taken at a rising edge where start is high and busy is low;
// it carries opcode, position and element. Every request gives one result
// on status, read_value and list_length, shown for exactly one cycle while
// done is high. The receiver cannot hold results off, and none is needed.
// The request is registered at the accepting edge, and the operation is
// applied to the list at the next edge, where done and the result are
// registered as well.
// A new request may be taken in every cycle: the whole operation is done in
// one cycle of combinational logic between the request register and the
// list and result registers, and each request sees the list left by the one
// before it.
// Synchronous reset empties the list and drops any request in flight; busy
// is high during reset and for one cycle after it. The entry storage is not
// cleared; entries at or beyond the length are never read.
module array_list_engine_core
  import ale_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode,
  input  logic [4:0] position,
  input  logic [7:0] element,
  output logic       done,
  output logic [1:0] status,
  output logic [7:0] read_value,
  output logic [4:0] list_length
);

  logic             in_valid;
  logic [2:0]       in_opcode;
  logic [4:0]       in_position;
  logic [7:0]       in_element;
  entry_array_t     entries;
  entry_array_t     entries_next;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  result_t          res;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_opcode   <= opcode;
      in_position <= position;
      in_element  <= element;
    end
  end

  ale_update u_update (
    .opcode       (in_opcode),
    .position     (in_position),
    .element      (in_element),
    .entries      (entries),
    .length       (length),
    .entries_next (entries_next),
    .length_next  (length_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (in_valid) begin
      entries <= entries_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
    end else begin
      done <= in_valid;
      if (in_valid) begin
        length <= length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      status      <= res.status;
      read_value  <= res.read_value;
      list_length <= 5'(length_next);
    end
  end

endmodule

### sim/tb_array_list_engine_core.sv
// Self-checking testbench for array_list_engine_core: drives list requests through the
// start/busy handshake and checks every done strobe against a shadow copy of the list.
// Depends on ale_pkg and the array list engine RTL.
`timescale 1ns / 100ps

module tb_array_list_engine_core;
  import ale_pkg::*;

  typedef struct {
    status_t    status;
    logic [7:0] read_value;
    logic [4:0] list_length;
  } list_outcome_t;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] opcode = '0;
  logic [4:0] position = '0;
  logic [7:0] element = '0;
  logic       busy;
  logic       done;
  logic [1:0] status;
  logic [7:0] read_value;
  logic [4:0] list_length;

  logic [7:0]    shadow_list [DEPTH];
  int            shadow_len = 0;
  list_outcome_t list_outcomes_due [$];
  int            mismatches = 0;
  bit            idling_on = 1'b1;

  array_list_engine_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .position    (position),
    .element     (element),
    .done        (done),
    .status      (status),
    .read_value  (read_value),
    .list_length (list_length)
  );

  always #6 clk = ~clk;

  function automatic void shadow_insert(int slot, logic [7:0] elem);
    for (int k = shadow_len; k > slot; k--) begin
      shadow_list[k] = shadow_list[k - 1];
    end
    shadow_list[slot] = elem;
    shadow_len++;
  endfunction

  function automatic list_outcome_t predict_list_outcome(logic [2:0] op, logic [4:0] pos,
                                                         logic [7:0] elem);
    list_outcome_t res;
    int slot;
    int kept;
    logic [7:0] swap;
    res.status = ST_OK;
    res.read_value = '0;
    case (op)
      OP_INSERT_AT: begin
        if (shadow_len >= DEPTH) res.status = ST_FULL;
        else if (int'(pos) > shadow_len) res.status = ST_BAD_POS;
        else shadow_insert(int'(pos), elem);
      end
      OP_REMOVE_VALUE: begin
        kept = 0;
        for (int k = 0; k < shadow_len; k++) begin
          if (shadow_list[k] != elem) begin
            shadow_list[kept] = shadow_list[k];
            kept++;
          end
        end
        if (kept == shadow_len) res.status = ST_NOT_FOUND;
        shadow_len = kept;
      end
      OP_SORTED_INSERT: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_len && elem >= shadow_list[slot]) slot++;
          shadow_insert(slot, elem);
        end
      end
      OP_REVERSE: begin
        for (int k = 0; k < shadow_len / 2; k++) begin
          swap = shadow_list[k];
          shadow_list[k] = shadow_list[shadow_len - 1 - k];
          shadow_list[shadow_len - 1 - k] = swap;
        end
      end
      OP_READ: begin
        if (int'(pos) < shadow_len) res.read_value = shadow_list[pos[IDX_W-1:0]];
        else res.status = ST_BAD_POS;
      end
      default: begin
      end
    endcase
    res.list_length = 5'(shadow_len);
    return res;
  endfunction

  task automatic issue_request(logic [2:0] op, logic [4:0] pos, logic [7:0] elem);
    start <= 1'b1;
    opcode <= op;
    position <= pos;
    element <= elem;
    @(posedge clk);
    while (busy) @(posedge clk);
    list_outcomes_due.push_back(predict_list_outcome(op, pos, elem));
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    opcode <= 3'($urandom_range(0, 7));
    position <= 5'($urandom_range(0, 31));
    element <= 8'($urandom_range(0, 255));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 7));
  endtask

  task automatic issue_random_request();
    logic [2:0] op;
    logic [4:0] pos;
    logic [7:0] elem;
    case ($urandom_range(0, 9))
      0, 1: op = OP_INSERT_AT;
      2, 3: op = OP_SORTED_INSERT;
      4, 5: op = OP_REMOVE_VALUE;
      6: op = OP_REVERSE;
      7, 8: op = OP_READ;
      default: op = 3'($urandom_range(0, 7));
    endcase
    if (shadow_len >= DEPTH - 2 && $urandom_range(0, 2) == 0) op = OP_REMOVE_VALUE;
    if ($urandom_range(0, 7) == 0) pos = 5'($urandom_range(0, 31));
    else pos = 5'($urandom_range(0, shadow_len));
    case ($urandom_range(0, 7))
      0: elem = 8'h00;
      1: elem = 8'hFF;
      default: elem = 8'($urandom_range(0, 255));
    endcase
    if (shadow_len > 0 && $urandom_range(0, 3) != 0 &&
        (op == OP_REMOVE_VALUE || $urandom_range(0, 2) == 0)) begin
      elem = shadow_list[IDX_W'($urandom_range(0, shadow_len - 1))];
    end
    maybe_idle();
    issue_request(op, pos, elem);
  endtask

  task automatic test_empty_list();
    issue_request(OP_REVERSE, 5'd0, 8'h00);
    issue_request(OP_READ, 5'd0, 8'h00);
    issue_request(OP_REMOVE_VALUE, 5'd0, 8'h00);
    issue_request(OP_INSERT_AT, 5'd1, 8'h5A);
  endtask

  task automatic test_basic_ops();
    issue_request(OP_INSERT_AT, 5'd0, 8'h00);
    issue_request(OP_INSERT_AT, 5'd1, 8'hFF);
    issue_request(OP_SORTED_INSERT, 5'd0, 8'h80);
    issue_request(OP_SORTED_INSERT, 5'd0, 8'hFF);
    issue_request(OP_REVERSE, 5'd0, 8'h00);
    issue_request(OP_READ, 5'd0, 8'h00);
    issue_request(OP_READ, 5'd4, 8'h00);
    issue_request(OP_REMOVE_VALUE, 5'd0, 8'hFF);
    issue_request(OP_REMOVE_VALUE, 5'd0, 8'h11);
  endtask

  task automatic test_full_list();
    while (shadow_len < DEPTH) begin
      issue_request(OP_INSERT_AT, (shadow_len % 2) ? 5'd0 : 5'(shadow_len),
                    8'($urandom_range(0, 255)));
    end
    issue_request(OP_INSERT_AT, 5'd31, 8'h33);
    issue_request(OP_SORTED_INSERT, 5'd0, 8'h33);
    issue_request(OP_READ, 5'd15, 8'h00);
    issue_request(OP_READ, 5'd16, 8'h00);
  endtask

  task automatic test_unused_opcodes();
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      issue_request(3'(op), 5'd31, 8'hFF);
    end
  endtask

  task automatic test_random_mix(int count);
    repeat (count) issue_random_request();
  endtask

  task automatic test_back_to_back(int count);
    idling_on = 1'b0;
    repeat (count) issue_random_request();
  endtask

  always @(posedge clk) begin : check_result
    list_outcome_t want;
    if (!rst && done) begin
      if (list_outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no request outstanding: status %0d value %0d length %0d",
                   $realtime, status, read_value, list_length);
        end
      end else begin
        want = list_outcomes_due.pop_front();
        if (status !== want.status || read_value !== want.read_value ||
            list_length !== want.list_length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected status %0d value %0d length %0d, got %0d %0d %0d",
                     $realtime, want.status, want.read_value, want.list_length,
                     status, read_value, list_length);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_unused_opcodes();
    test_random_mix(1000);
    test_back_to_back(130);
    start <= 1'b0;
    while (list_outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
